/* design/cda_pkg.sv */
// Shared types, constants and the month-length function for the calendar date block.
// No dependencies; used by every module under design/.
package cda_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;

  localparam logic [YEAR_W-1:0] YEAR_MAX     = 14'd9999;
  localparam logic [YEAR_W-1:0] YEAR_RST     = 14'd2000;
  localparam logic [YEAR_W-1:0] CUTOVER_YEAR = 14'd1916;

  localparam logic [DAY_W-1:0] DAY_FIRST    = 5'd1;
  localparam logic [DAY_W-1:0] DAY_CUT_FROM = 5'd31;
  localparam logic [DAY_W-1:0] DAY_CUT_TO   = 5'd14;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // y / 100 == (y * 5243) >> 19, exact for y < 43690
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam int unsigned QUOT_W       = 7;
  localparam int unsigned PROD_W       = 27;

  localparam int unsigned TDATA_W = 24;

  typedef enum logic {
    KIND_ADVANCE = 1'b0,
    KIND_LOAD    = 1'b1
  } kind_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    kind_t              kind;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } item_t;

  // month is expected in 1..12; anything else reads as a 31-day month
  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                               input logic leap);
    unique case (month)
      MONTH_FEB: return leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

endpackage

/* design/cda_leap.sv */
// Leap year test: Julian rule up to the cutover year, Gregorian after it.
// Depends on cda_pkg; divide by 100 is a reciprocal multiply.
module cda_leap (
  input  logic [cda_pkg::YEAR_W-1:0] year_i,
  output logic                       leap_o
);

  logic [cda_pkg::PROD_W-1:0] prod;
  logic [cda_pkg::QUOT_W-1:0] quot;
  logic [cda_pkg::YEAR_W-1:0] hund;
  logic [cda_pkg::QUOT_W-1:0] rem;
  logic                       div4;
  logic                       div100;
  logic                       div400;

  always_comb begin
    prod   = cda_pkg::PROD_W'(year_i) * cda_pkg::PROD_W'(cda_pkg::DIV100_MUL);
    quot   = prod[cda_pkg::DIV100_SHIFT +: cda_pkg::QUOT_W];
    // quot * 100 = quot * (64 + 32 + 4)
    hund   = cda_pkg::YEAR_W'({quot, 6'b0}) + cda_pkg::YEAR_W'({quot, 5'b0})
           + cda_pkg::YEAR_W'({quot, 2'b0});
    rem    = cda_pkg::QUOT_W'(year_i - hund);
    div4   = (year_i[1:0] == 2'b00);
    div100 = (rem == '0);
    div400 = div100 && (quot[1:0] == 2'b00);
    if (year_i <= cda_pkg::CUTOVER_YEAR) begin
      leap_o = div4;
    end else begin
      leap_o = (div4 && !div100) || div400;
    end
  end

endmodule

/* design/cda_step.sv */
// Next-date logic: load with clamping, or advance one day with the cutover jump.
// Depends on cda_pkg and cda_leap.
module cda_step (
  input  cda_pkg::item_t item_i,
  input  cda_pkg::date_t cur_i,
  output cda_pkg::date_t nxt_o,
  output logic           leap_o
);

  logic [cda_pkg::YEAR_W-1:0]  year_cl;
  logic [cda_pkg::MONTH_W-1:0] month_cl;
  logic [cda_pkg::YEAR_W-1:0]  year_sel;
  logic [cda_pkg::MONTH_W-1:0] month_sel;
  logic [cda_pkg::YEAR_W-1:0]  year_inc;
  logic [cda_pkg::DAY_W-1:0]   dlen;
  logic                        leap_sel;
  logic                        leap_inc;
  logic                        is_load;

  assign is_load = (item_i.kind == cda_pkg::KIND_LOAD);

  always_comb begin
    year_cl  = (item_i.year > cda_pkg::YEAR_MAX) ? cda_pkg::YEAR_MAX : item_i.year;
    month_cl = (item_i.month == '0 || item_i.month > cda_pkg::MONTH_DEC) ?
               cda_pkg::MONTH_JAN : item_i.month;
    year_sel  = is_load ? year_cl : cur_i.year;
    month_sel = is_load ? month_cl : cur_i.month;
    year_inc  = (cur_i.year >= cda_pkg::YEAR_MAX) ? '0 : cur_i.year + 1'b1;
  end

  cda_leap u_leap_sel (
    .year_i (year_sel),
    .leap_o (leap_sel)
  );

  cda_leap u_leap_inc (
    .year_i (year_inc),
    .leap_o (leap_inc)
  );

  assign dlen = cda_pkg::days_in(month_sel, leap_sel);

  always_comb begin
    nxt_o  = cur_i;
    leap_o = leap_sel;
    priority if (is_load) begin
      nxt_o.year  = year_cl;
      nxt_o.month = month_cl;
      nxt_o.day   = (item_i.day == '0 || item_i.day > dlen) ? cda_pkg::DAY_FIRST : item_i.day;
    end else if (cur_i.year == cda_pkg::CUTOVER_YEAR && cur_i.month == cda_pkg::MONTH_MAR &&
                 cur_i.day == cda_pkg::DAY_CUT_FROM) begin
      nxt_o.day   = cda_pkg::DAY_CUT_TO;
      nxt_o.month = cda_pkg::MONTH_APR;
    end else if (cur_i.day < dlen) begin
      nxt_o.day = cur_i.day + 1'b1;
    end else if (cur_i.month >= cda_pkg::MONTH_DEC) begin
      nxt_o.day   = cda_pkg::DAY_FIRST;
      nxt_o.month = cda_pkg::MONTH_JAN;
      nxt_o.year  = year_inc;
      leap_o      = leap_inc;
    end else begin
      nxt_o.day   = cda_pkg::DAY_FIRST;
      nxt_o.month = cur_i.month + 1'b1;
    end
  end

endmodule

/* design/calendar_date_advance_with_cutover.sv */
// Top level of the calendar date block: input register, next-date logic, result register.
// Depends on cda_pkg, cda_leap and cda_step.
//
// Holds a date (reset 1 January 2000) and answers every input transfer with one
// result transfer carrying the date after that item and its leap flag. A load
// (in_tuser = 1) sets a clamped date; an advance (in_tuser = 0) steps one day,
// with Julian leap years up to 1916, Gregorian after, 31 March 1916 followed by
// 14 April, and year 9999 wrapping to 0. One item is taken every clock cycle while
// the result side is not stalled; each result passes through the input register and
// then the result register before it is offered. The rate is set by the combinational
// next-date path, whose longest leg is the divide-by-100 reciprocal multiply in the
// leap test. The result register lets a new item enter while an earlier result is
// still held.
module calendar_date_advance_with_cutover (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [cda_pkg::TDATA_W-1:0]  in_tdata,   // load_day[4:0], load_month[8:5],
                                                   // load_year[22:9], zero[23]
  input  logic                         in_tuser,   // kind
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [cda_pkg::TDATA_W-1:0]  out_tdata   // cur_day[4:0], cur_month[8:5],
                                                   // cur_year[22:9], leap_flag[23]
);

  cda_pkg::item_t               s1_r;
  logic                         s1_valid_r;
  cda_pkg::date_t               date_r;
  cda_pkg::date_t               date_nxt;
  logic                         leap_nxt;
  logic [cda_pkg::TDATA_W-1:0]  out_data_r;
  logic                         out_valid_r;
  logic                         s2_en;
  logic                         step;
  logic                         in_xfer;

  assign s2_en     = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_en;
  assign in_xfer   = in_tvalid && in_tready;
  assign step      = s1_valid_r && s2_en;

  cda_step u_step (
    .item_i (s1_r),
    .cur_i  (date_r),
    .nxt_o  (date_nxt),
    .leap_o (leap_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      date_r.year  <= cda_pkg::YEAR_RST;
      date_r.month <= cda_pkg::MONTH_JAN;
      date_r.day   <= cda_pkg::DAY_FIRST;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s2_en) begin
        out_valid_r <= s1_valid_r;
      end
      if (step) begin
        date_r <= date_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r.kind  <= cda_pkg::kind_t'(in_tuser);
      s1_r.day   <= in_tdata[4:0];
      s1_r.month <= in_tdata[8:5];
      s1_r.year  <= in_tdata[22:9];
    end
    if (step) begin
      out_data_r <= {leap_nxt, date_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_result_is_state : assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (out_data_r[22:0] == date_r))
    else $error("result register does not match held date");

  a_stall_holds_input : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while both stages are stalled");

  a_state_legal : assert property (@(posedge clk) disable iff (!rst_n)
    (date_r.month >= cda_pkg::MONTH_JAN) && (date_r.month <= cda_pkg::MONTH_DEC) &&
    (date_r.day != '0) && (date_r.year <= cda_pkg::YEAR_MAX))
    else $error("held date out of range");

endmodule

/* test/tb.sv */
// Self-checking testbench for calendar_date_advance_with_cutover: directed and random
// loads and day advances, predicted in-bench and checked per transfer. Depends on cda_pkg.
module tb;

  localparam int unsigned CUTOVER        = 1916;
  localparam int unsigned LAST_YEAR      = 9999;
  localparam int unsigned RANDOM_ITEMS   = 750;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  typedef struct {
    cda_pkg::kind_t              kind;
    logic [cda_pkg::DAY_W-1:0]   day;
    logic [cda_pkg::MONTH_W-1:0] month;
    logic [cda_pkg::YEAR_W-1:0]  year;
  } date_cmd_t;

  typedef struct {
    logic [cda_pkg::DAY_W-1:0]   day;
    logic [cda_pkg::MONTH_W-1:0] month;
    logic [cda_pkg::YEAR_W-1:0]  year;
    logic                        leap;
  } date_view_t;

  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         in_tvalid  = 1'b0;
  logic                         in_tready;
  logic [cda_pkg::TDATA_W-1:0]  in_tdata   = '0;   // load_day[4:0], load_month[8:5],
                                                   // load_year[22:9], zero[23]
  logic                         in_tuser   = 1'b0; // kind
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [cda_pkg::TDATA_W-1:0]  out_tdata;         // cur_day[4:0], cur_month[8:5],
                                                   // cur_year[22:9], leap_flag[23]

  date_cmd_t  cmd_queue[$];
  date_view_t expected_dates[$];

  logic [cda_pkg::DAY_W-1:0]   cal_day   = 5'd1;
  logic [cda_pkg::MONTH_W-1:0] cal_month = 4'd1;
  logic [cda_pkg::YEAR_W-1:0]  cal_year  = 14'd2000;

  int errors         = 0;
  int results_seen   = 0;
  int items_made     = 0;
  int idle_cycles    = 0;
  int tx_gap         = 0;
  int tx_calm        = 0;
  int rx_stall       = 0;
  int rx_calm        = 0;
  bit long_hold_done = 1'b0;
  bit in_taken       = 1'b0;
  bit out_taken      = 1'b0;

  calendar_date_advance_with_cutover i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic bit leap_year(input logic [cda_pkg::YEAR_W-1:0] y);
    int unsigned v;
    v = y;
    if (v <= CUTOVER) return (v % 4) == 0;
    return ((v % 4) == 0 && (v % 100) != 0) || (v % 400) == 0;
  endfunction

  function automatic int unsigned month_days(input logic [cda_pkg::MONTH_W-1:0] m,
                                             input logic [cda_pkg::YEAR_W-1:0] y);
    case (m)
      4'd2: return leap_year(y) ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11: return 30;
      default: return 31;
    endcase
  endfunction

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int next_idle(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(99) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic predict_date(input cda_pkg::kind_t kind,
                              input logic [cda_pkg::DAY_W-1:0] d,
                              input logic [cda_pkg::MONTH_W-1:0] m,
                              input logic [cda_pkg::YEAR_W-1:0] y);
    date_view_t v;
    if (kind == cda_pkg::KIND_LOAD) begin
      if (y > LAST_YEAR) y = cda_pkg::YEAR_W'(LAST_YEAR);
      if (m == 0 || m > 12) m = 4'd1;
      if (d == 0 || d > month_days(m, y)) d = 5'd1;
      cal_day   = d;
      cal_month = m;
      cal_year  = y;
    end else if (cal_year == CUTOVER && cal_month == 4'd3 && cal_day == 5'd31) begin
      cal_day   = 5'd14;
      cal_month = 4'd4;
    end else if (cal_day < month_days(cal_month, cal_year)) begin
      cal_day = cal_day + 5'd1;
    end else begin
      cal_day = 5'd1;
      if (cal_month >= 12) begin
        cal_month = 4'd1;
        cal_year  = (cal_year >= LAST_YEAR) ? 14'd0 : cal_year + 14'd1;
      end else begin
        cal_month = cal_month + 4'd1;
      end
    end
    v.day   = cal_day;
    v.month = cal_month;
    v.year  = cal_year;
    v.leap  = leap_year(cal_year);
    expected_dates.push_back(v);
  endtask

  task automatic add_cmd(input cda_pkg::kind_t k, input int d, input int m, input int y);
    date_cmd_t c;
    c.kind  = k;
    c.day   = d[cda_pkg::DAY_W-1:0];
    c.month = m[cda_pkg::MONTH_W-1:0];
    c.year  = y[cda_pkg::YEAR_W-1:0];
    cmd_queue.push_back(c);
    items_made++;
  endtask

  task automatic add_advances(input int n);
    repeat (n) add_cmd(cda_pkg::KIND_ADVANCE, 0, 0, 0);
  endtask

  task automatic gen_random(input int upto);
    int m, y, len, d;
    while (items_made < upto) begin
      case ($urandom_range(15))
        0, 1: begin
          add_cmd(cda_pkg::kind_t'($urandom_range(1)), $urandom_range(31),
                  $urandom_range(15), $urandom_range(16383));
        end
        2: begin
          add_cmd(cda_pkg::KIND_LOAD, $urandom_range(20, 31), 3, CUTOVER);
          add_advances($urandom_range(10, 30));
        end
        default: begin
          m = ($urandom_range(3) == 0) ? 12 : $urandom_range(1, 12);
          case ($urandom_range(7))
            0: y = CUTOVER;
            1: y = LAST_YEAR;
            2: y = 1900;
            3: y = 2000;
            4: y = 2100;
            5: y = $urandom_range(CUTOVER - 4, CUTOVER + 4);
            default: y = $urandom_range(LAST_YEAR);
          endcase
          len = month_days(m[cda_pkg::MONTH_W-1:0], y[cda_pkg::YEAR_W-1:0]);
          d = ($urandom_range(9) == 0) ? len + 1 : len - $urandom_range(3);
          add_cmd(cda_pkg::KIND_LOAD, d, m, y);
          add_advances($urandom_range(1, 40));
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || in_tvalid || expected_dates.size() != 0)
      @(posedge clk);
  endtask

  always @(negedge clk) begin : drive_input
    date_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        c = cmd_queue.pop_front();
        in_tdata  <= {1'b0, c.year, c.month, c.day};
        in_tuser  <= c.kind;
        in_tvalid <= 1'b1;
        tx_gap = next_idle(tx_calm);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_taken) begin
        rx_stall = next_idle(rx_calm);
        // long hold-off so the block fills and stalls its input
        if (results_seen >= 250 && !long_hold_done) begin
          rx_stall = 400;
          long_hold_done = 1'b1;
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_dates
    date_view_t want, got;
    in_taken  <= in_tvalid && in_tready;
    out_taken <= out_tvalid && out_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.day   = out_tdata[4:0];
        got.month = out_tdata[8:5];
        got.year  = out_tdata[22:9];
        got.leap  = out_tdata[23];
        results_seen++;
        if (expected_dates.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, got %0d/%0d/%0d leap %0b", $time,
                   got.day, got.month, got.year, got.leap);
        end else begin
          want = expected_dates.pop_front();
          if (got.day !== want.day) begin
            errors++;
            $display("%0t: cur_day expected %0d, got %0d", $time, want.day, got.day);
          end
          if (got.month !== want.month) begin
            errors++;
            $display("%0t: cur_month expected %0d, got %0d", $time, want.month, got.month);
          end
          if (got.year !== want.year) begin
            errors++;
            $display("%0t: cur_year expected %0d, got %0d", $time, want.year, got.year);
          end
          if (got.leap !== want.leap) begin
            errors++;
            $display("%0t: leap_flag expected %0b, got %0b", $time, want.leap, got.leap);
          end
        end
      end
      if (in_tvalid && in_tready)
        predict_date(cda_pkg::kind_t'(in_tuser), in_tdata[4:0], in_tdata[8:5],
                     in_tdata[22:9]);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : run_test
    int base;
    // directed: reset date, wraps, cutover, leap rules, clamping
    add_advances(1);
    add_cmd(cda_pkg::KIND_LOAD, 31, 12, LAST_YEAR);
    add_advances(2);
    add_cmd(cda_pkg::KIND_LOAD, 31, 3, CUTOVER);
    add_advances(2);
    add_cmd(cda_pkg::KIND_LOAD, 28, 2, 1900);
    add_advances(2);
    add_cmd(cda_pkg::KIND_LOAD, 28, 2, 2100);
    add_advances(1);
    add_cmd(cda_pkg::KIND_LOAD, 29, 2, 2000);
    add_advances(1);
    add_cmd(cda_pkg::KIND_LOAD, 29, 2, 2001);
    add_cmd(cda_pkg::KIND_LOAD, 15, 0, 2020);
    add_cmd(cda_pkg::KIND_LOAD, 10, 15, 2020);
    add_cmd(cda_pkg::KIND_LOAD, 10, 13, 2020);
    add_cmd(cda_pkg::KIND_LOAD, 0, 5, 2020);
    add_cmd(cda_pkg::KIND_LOAD, 31, 4, 2020);
    add_cmd(cda_pkg::KIND_LOAD, 31, 12, 16383);
    add_advances(1);
    add_cmd(cda_pkg::KIND_LOAD, 31, 12, CUTOVER);
    add_advances(1);
    base = items_made;

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    wait_drained();
    gen_random(base + RANDOM_ITEMS / 2);
    wait_drained();
    gen_random(base + RANDOM_ITEMS);
    wait_drained();
    repeat (8) @(posedge clk);

    if (expected_dates.size() != 0) begin
      errors += expected_dates.size();
      $display("%0t: %0d expected results never arrived", $time, expected_dates.size());
    end
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
